// ===== rtl/intf_pkg.sv =====
// shared types, constants and helpers of the impulse noise threshold filter
// no dependencies

package intf_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);
	localparam int FILL_W    = $clog2(MAX_WIDTH + 2);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

	localparam logic [11:0] WIDTH_RESET  = 12'd640;
	localparam logic [15:0] HEIGHT_RESET = 16'd480;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} intf_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       replaced;
		logic       last_of_frame;
	} intf_out_t;

	typedef logic [23:0] rgb_t;

	// (11r + 16g + 5b) / 32, truncated
	function automatic logic [7:0] gray_of(input rgb_t rgb);
		logic [12:0] acc;
		acc = 13'd11 * 13'(rgb[23:16]) + 13'd16 * 13'(rgb[15:8]) + 13'd5 * 13'(rgb[7:0]);
		return acc[12:5];
	endfunction

endpackage

// ===== rtl/impulse_noise_threshold_filter_core.sv =====
// impulse noise threshold filter, 3x3 window over a raster rgb stream
// two line memories (gray of the upper row, colour of the centre row)
// depends on intf_pkg
// pipeline: a transaction passes the stage 1, stage 2 and output registers; results
//   trail the input stream by the effective image width + 1 positions
// throughput: one transaction per cycle unless out_ready stalls, set by the single
//   read-modify-write pass over the memories (width of 1 forwards the previous write)
// reset: positions, fill count, window, held colour and valid flags cleared; line
//   memories are not cleared and need no clearing pass

module impulse_noise_threshold_filter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [intf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [intf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  intf_pkg::intf_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output intf_pkg::intf_out_t                 out_data
);

	localparam int COL_W   = intf_pkg::COL_W;
	localparam int WIDTH_W = intf_pkg::WIDTH_W;
	localparam int FILL_W  = intf_pkg::FILL_W;
	localparam int CMP_W   = (WIDTH_W > 12) ? WIDTH_W : 12;

	// configuration
	logic [7:0]  threshold_q;
	logic [11:0] image_width_q;
	logic [15:0] image_height_q;
	logic        restart;

	// effective geometry
	logic [CMP_W-1:0]   iw_ext;
	logic [WIDTH_W-1:0] w_eff;
	logic [15:0]        h_eff;

	// input and output positions
	logic [COL_W-1:0]   in_col_q;
	logic [15:0]        in_row_q;
	logic [COL_W-1:0]   out_col_q;
	logic [15:0]        out_row_q;
	logic [FILL_W-1:0]  fill_q;

	// stage 0 decode
	logic               draining;
	logic               accept;
	logic               step;
	logic [WIDTH_W-1:0] in_col_inc;
	logic [WIDTH_W-1:0] out_col_inc;
	logic               in_wrap;
	logic               out_wrap;
	logic               emit;
	logic               last;
	logic               interior;
	intf_pkg::rgb_t     cur;

	// pipeline control
	logic en_o;
	logic en2;
	logic en1;
	logic adv1;

	// line memories
	intf_pkg::rgb_t colour_mem [intf_pkg::MAX_WIDTH];
	logic [7:0]     gray_mem   [intf_pkg::MAX_WIDTH];
	intf_pkg::rgb_t colour_rd_q;
	logic [7:0]     gray_rd_q;
	intf_pkg::rgb_t fwd_colour_q;
	logic [7:0]     fwd_gray_q;

	// stage 1
	logic             v_s1;
	logic [COL_W-1:0] col_s1;
	intf_pkg::rgb_t   cur_s1;
	logic             emit_s1;
	logic             last_s1;
	logic             int_s1;
	logic             fwd_s1;
	intf_pkg::rgb_t   mid;
	logic [7:0]       up_gray;
	logic [7:0]       mid_gray;
	logic [7:0]       cur_gray;

	// stage 2
	logic           v_s2;
	intf_pkg::rgb_t rgb_s2;
	logic           emit_s2;
	logic           last_s2;
	logic           int_s2;
	logic [7:0]     win_q [9];
	intf_pkg::rgb_t held_q;
	logic [10:0]    sum;
	logic [7:0]     mean;
	logic [7:0]     diff;
	logic           rep;

	// output register
	logic                out_valid_q;
	intf_pkg::intf_out_t out_q;

	assign restart = cfg_write &&
		(cfg_index == intf_pkg::CFG_IMAGE_WIDTH || cfg_index == intf_pkg::CFG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= '0;
			image_width_q  <= intf_pkg::WIDTH_RESET;
			image_height_q <= intf_pkg::HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				intf_pkg::CFG_THRESHOLD:    threshold_q    <= cfg_data[7:0];
				intf_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[11:0];
				intf_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		iw_ext = CMP_W'(image_width_q);
		if (image_width_q == '0)
			w_eff = WIDTH_W'(1);
		else if (iw_ext > CMP_W'(intf_pkg::MAX_WIDTH))
			w_eff = WIDTH_W'(intf_pkg::MAX_WIDTH);
		else
			w_eff = WIDTH_W'(iw_ext);
		h_eff = (image_height_q == '0) ? 16'd1 : image_height_q;
	end

	assign en_o = !out_valid_q || out_ready;
	assign en2  = !v_s2 || en_o;
	assign en1  = !v_s1 || en2;
	assign adv1 = v_s1 && en2;

	assign in_ready = en1;
	assign accept   = in_valid && en1;
	assign draining = in_row_q >= h_eff;
	assign step     = accept && !(in_data.command == intf_pkg::CMD_DRAIN && !draining);

	always_comb begin
		cur = draining ? '0 : {in_data.red_in, in_data.green_in, in_data.blue_in};
		in_col_inc  = WIDTH_W'(in_col_q) + WIDTH_W'(1);
		out_col_inc = WIDTH_W'(out_col_q) + WIDTH_W'(1);
		in_wrap  = in_col_inc >= w_eff;
		out_wrap = out_col_inc >= w_eff;
		emit = fill_q >= (FILL_W'(w_eff) + FILL_W'(1));
		last = (out_row_q == h_eff - 16'd1) && (WIDTH_W'(out_col_q) == w_eff - WIDTH_W'(1));
		interior = (w_eff >= WIDTH_W'(3)) && (h_eff >= 16'd3) &&
			(out_row_q >= 16'd1) && (out_row_q <= h_eff - 16'd2) &&
			(out_col_q != '0) && (WIDTH_W'(out_col_q) <= w_eff - WIDTH_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			fill_q    <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			fill_q    <= '0;
		end else if (step) begin
			if (emit && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				fill_q    <= '0;
			end else begin
				if (in_wrap) begin
					in_col_q <= '0;
					if (!draining)
						in_row_q <= in_row_q + 16'd1;
				end else begin
					in_col_q <= COL_W'(in_col_inc);
				end
				if (emit) begin
					if (out_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 16'd1;
					end else begin
						out_col_q <= COL_W'(out_col_inc);
					end
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	// line memories: read on transaction, write when the item leaves stage 1
	always_ff @(posedge clk) begin
		if (step) begin
			colour_rd_q <= colour_mem[in_col_q];
			gray_rd_q   <= gray_mem[in_col_q];
		end
		if (adv1) begin
			colour_mem[col_s1] <= cur_s1;
			gray_mem[col_s1]   <= mid_gray;
		end
	end

	always_comb begin
		mid      = fwd_s1 ? fwd_colour_q : colour_rd_q;
		up_gray  = fwd_s1 ? fwd_gray_q : gray_rd_q;
		mid_gray = intf_pkg::gray_of(mid);
		cur_gray = intf_pkg::gray_of(cur_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (en1) begin
			v_s1   <= step;
			fwd_s1 <= v_s1 && (col_s1 == in_col_q);
		end
	end

	// same entry read while the older item writes it: forward
	always_ff @(posedge clk) begin
		if (en1 && step) begin
			col_s1       <= in_col_q;
			cur_s1       <= cur;
			emit_s1      <= emit;
			last_s1      <= last;
			int_s1       <= interior;
			fwd_colour_q <= cur_s1;
			fwd_gray_q   <= mid_gray;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			rgb_s2  <= held_q;
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			int_s2  <= int_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (restart) begin
			held_q <= '0;
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (adv1) begin
			held_q <= mid;
			for (int r = 0; r < 3; r++) begin
				win_q[r * 3]     <= win_q[r * 3 + 1];
				win_q[r * 3 + 1] <= win_q[r * 3 + 2];
			end
			win_q[2] <= up_gray;
			win_q[5] <= mid_gray;
			win_q[8] <= cur_gray;
		end
	end

	always_comb begin
		sum = ((11'(win_q[0]) + 11'(win_q[1])) + (11'(win_q[2]) + 11'(win_q[3]))) +
			((11'(win_q[5]) + 11'(win_q[6])) + (11'(win_q[7]) + 11'(win_q[8])));
		mean = sum[10:3];
		diff = (win_q[4] > mean) ? (win_q[4] - mean) : (mean - win_q[4]);
		rep  = int_s2 && (diff > threshold_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_o) begin
			out_valid_q <= v_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && v_s2) begin
			out_q.red_out       <= rep ? mean : rgb_s2[23:16];
			out_q.green_out     <= rep ? mean : rgb_s2[15:8];
			out_q.blue_out      <= rep ? mean : rgb_s2[7:0];
			out_q.replaced      <= rep;
			out_q.last_of_frame <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== dv/impulse_filter_checker.sv =====
// checker for the impulse noise threshold filter: snoops the register port and both
// channels, predicts every filtered pixel and compares transactions in order
// depends on intf_pkg

module impulse_filter_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [intf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [intf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  intf_pkg::intf_in_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  intf_pkg::intf_out_t             out_data,
	output int unsigned                     pending,
	output int unsigned                     fault_count
);

	import intf_pkg::*;

	logic [7:0]  thresh_reg;
	logic [11:0] width_reg;
	logic [15:0] height_reg;

	logic [7:0]  upper_gray [MAX_WIDTH];
	rgb_t        centre_rgb [MAX_WIDTH];
	logic [7:0]  gray_win [9];
	int unsigned in_col, in_row, out_col, out_row, fill_level;
	rgb_t        held_rgb;

	intf_out_t   expected_pixels [$];

	initial fault_count = 0;

	function automatic logic [7:0] luma(input rgb_t c);
		int unsigned acc;
		acc = 11 * c[23:16] + 16 * c[15:8] + 5 * c[7:0];
		return 8'(acc >> 5);
	endfunction

	function automatic void restart_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		fill_level = 0;
		held_rgb = '0;
		for (int k = 0; k < 9; k++) gray_win[k] = '0;
	endfunction

	task automatic report_fault(input string msg);
		$display("filter check: %s", msg);
		fault_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		int unsigned w, h, col, sum, mean, centre, diff;
		bit          draining;
		rgb_t        cur, mid, colour;
		logic [7:0]  mid_gray;
		intf_out_t   got, want;
		if (!arst_n) begin
			thresh_reg = '0;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			restart_frame();
			expected_pixels.delete();
			pending <= 0;
		end else begin
			// result side first: an output never belongs to an input of the same edge
			if (out_valid && out_ready) begin
				got = out_data;
				if (expected_pixels.size() == 0) begin
					report_fault($sformatf("unexpected pixel %h", got));
				end else begin
					want = expected_pixels.pop_front();
					if (got.red_out !== want.red_out)
						report_fault($sformatf("red_out %h, expected %h",
							got.red_out, want.red_out));
					if (got.green_out !== want.green_out)
						report_fault($sformatf("green_out %h, expected %h",
							got.green_out, want.green_out));
					if (got.blue_out !== want.blue_out)
						report_fault($sformatf("blue_out %h, expected %h",
							got.blue_out, want.blue_out));
					if (got.replaced !== want.replaced)
						report_fault($sformatf("replaced %b, expected %b",
							got.replaced, want.replaced));
					if (got.last_of_frame !== want.last_of_frame)
						report_fault($sformatf("last_of_frame %b, expected %b",
							got.last_of_frame, want.last_of_frame));
				end
			end

			if (cfg_write) begin
				case (cfg_index)
					CFG_THRESHOLD: begin
						thresh_reg = cfg_data[7:0];
					end
					CFG_IMAGE_WIDTH: begin
						width_reg = cfg_data[11:0];
						restart_frame();
					end
					CFG_IMAGE_HEIGHT: begin
						height_reg = cfg_data[15:0];
						restart_frame();
					end
					default: begin
					end
				endcase
			end

			if (in_valid && in_ready) begin
				w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
				h = (height_reg == 0) ? 1 : height_reg;
				draining = (in_row >= h);
				// early drain ticks leave everything untouched
				if (!(in_data.command == CMD_DRAIN && !draining)) begin
					cur = draining ? '0 : {in_data.red_in, in_data.green_in, in_data.blue_in};
					col = (in_col < w) ? in_col : 0;
					mid = centre_rgb[col];
					mid_gray = luma(mid);
					for (int r = 0; r < 3; r++) begin
						gray_win[3 * r] = gray_win[3 * r + 1];
						gray_win[3 * r + 1] = gray_win[3 * r + 2];
					end
					gray_win[2] = upper_gray[col];
					gray_win[5] = mid_gray;
					gray_win[8] = luma(cur);
					upper_gray[col] = mid_gray;
					centre_rgb[col] = cur;

					in_col = col + 1;
					if (in_col >= w) begin
						in_col = 0;
						if (!draining) in_row++;
					end

					if (fill_level >= w + 1) begin
						colour = held_rgb;
						want.replaced = 1'b0;
						want.last_of_frame = (out_row == h - 1 && out_col == w - 1);
						if (w >= 3 && h >= 3 && out_row >= 1 && out_row <= h - 2 &&
							out_col >= 1 && out_col <= w - 2) begin
							sum = 0;
							for (int k = 0; k < 9; k++)
								if (k != 4) sum += gray_win[k];
							mean = sum >> 3;
							centre = gray_win[4];
							diff = (centre > mean) ? centre - mean : mean - centre;
							if (diff > thresh_reg) begin
								colour = {3{mean[7:0]}};
								want.replaced = 1'b1;
							end
						end
						want.red_out = colour[23:16];
						want.green_out = colour[15:8];
						want.blue_out = colour[7:0];
						expected_pixels.push_back(want);

						if (want.last_of_frame) begin
							in_col = 0;
							in_row = 0;
							out_col = 0;
							out_row = 0;
							fill_level = 0;
						end else begin
							out_col++;
							if (out_col >= w) begin
								out_col = 0;
								out_row++;
							end
						end
					end else begin
						fill_level++;
					end
					held_rgb = mid;
				end
			end
			pending <= expected_pixels.size();
		end
	end

endmodule

// ===== dv/impulse_noise_threshold_filter_core_test.sv =====
// testbench top of the impulse noise threshold filter: resets, programs the
// geometry, streams directed and random frames with idling and gives the verdict
// depends on intf_pkg, impulse_filter_checker and impulse_noise_threshold_filter_core

module impulse_noise_threshold_filter_core_test;

	import intf_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned RANDOM_ITEMS   = 1050;
	localparam int unsigned SETTLE_CYCLES  = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	intf_in_t              in_data;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	intf_out_t             out_data;
	int unsigned           pending;
	int unsigned           fault_count;

	int unsigned send_gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned idle_cycles = 0;
	int unsigned items_sent = 0;
	int unsigned eff_w = 1;
	int unsigned eff_h = 1;
	rgb_t        scene_rgb = '0;

	impulse_noise_threshold_filter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	impulse_filter_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.pending     (pending),
		.fault_count (fault_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// mostly a flat scene with small jitter, plus white, black and random impulses
	function automatic rgb_t pixel_colour();
		rgb_t res;
		int   v;
		case ($urandom_range(9))
			0: res = 24'h000000;
			1: res = 24'hFFFFFF;
			2, 3: res = 24'($urandom);
			default: begin
				for (int k = 0; k < 3; k++) begin
					v = int'(scene_rgb[8 * k +: 8]) + int'($urandom_range(16)) - 8;
					if (v < 0) v = 0;
					if (v > 255) v = 255;
					res[8 * k +: 8] = 8'(v);
				end
			end
		endcase
		return res;
	endfunction

	task automatic send(input logic cmd, input rgb_t colour);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{command: cmd, red_in: colour[23:16], green_in: colour[15:8],
			blue_in: colour[7:0]};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] word);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		@(posedge clk);
	endtask

	task automatic configure(input logic [15:0] thr_word, input logic [15:0] width_word,
		input logic [15:0] height_word);
		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_THRESHOLD, thr_word);
		write_reg(CFG_IMAGE_WIDTH, width_word);
		write_reg(CFG_IMAGE_HEIGHT, height_word);
		cfg_write <= 1'b0;
		eff_w = (width_word[11:0] == 0) ? 1 :
			((width_word[11:0] > MAX_WIDTH) ? MAX_WIDTH : width_word[11:0]);
		eff_h = (height_word == 0) ? 1 : height_word;
	endtask

	task automatic send_frame(input int unsigned pixel_count, input bit complete);
		for (int unsigned i = 0; i < pixel_count; i++) begin
			if ($urandom_range(24) == 0) send(CMD_DRAIN, 24'($urandom));
			if ($urandom_range(199) == 0) quiesce();
			send(CMD_PIXEL, pixel_colour());
			items_sent++;
		end
		if (complete) begin
			for (int unsigned i = 0; i <= eff_w; i++) begin
				send(($urandom_range(4) == 0) ? CMD_PIXEL : CMD_DRAIN, 24'($urandom));
				items_sent++;
			end
		end
	endtask

	initial begin : stimulus
		rgb_t        spike_frame [9];
		int unsigned episode;
		int unsigned frames;
		int unsigned saved_count;
		logic [15:0] thr_word, width_word, height_word;

		spike_frame = '{24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'h000000, 24'hFFFFFF, 24'h000000,
			24'hFFFFFF, 24'h000000, 24'h808080};
		cfg_write <= 1'b0;
		cfg_index <= CFG_THRESHOLD;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 frame with a white spike in the middle
		configure(16'd40, 16'd3, 16'd3);
		for (int i = 0; i < 9; i++) begin
			send(CMD_PIXEL, spike_frame[i]);
			if (i == 2) send(CMD_DRAIN, 24'hFFFFFF);
			if (i == 5) quiesce();
		end
		send(CMD_DRAIN, 24'h000000);
		send(CMD_PIXEL, 24'hFFFFFF);
		send(CMD_DRAIN, 24'h123456);
		send(CMD_DRAIN, 24'h000000);

		// single pixel frame, result only after the second drain
		configure(16'd255, 16'd1, 16'd1);
		send(CMD_PIXEL, 24'hA5A5A5);
		send(CMD_DRAIN, 24'h000000);
		send(CMD_DRAIN, 24'h000000);

		episode = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case ((episode / 3) % 4)
				0: begin
					send_gap_pct <= 0;
					stall_pct <= 0;
				end
				1: begin
					send_gap_pct <= 51;
					stall_pct <= 0;
				end
				2: begin
					send_gap_pct <= 0;
					stall_pct <= 51;
				end
				default: begin
					send_gap_pct <= 22;
					stall_pct <= 22;
				end
			endcase

			if (episode == 6) begin
				// widest and tallest geometry, cut short before the first output row is complete
				saved_count = items_sent;
				configure(16'($urandom), 16'hFFFF, 16'hFFFF);
				scene_rgb = 24'($urandom);
				send_frame(eff_w + 41, 1'b0);
				items_sent = saved_count;
			end else begin
				case ($urandom_range(9))
					0: thr_word = 16'd0;
					1: thr_word = 16'd255;
					2, 3, 4: thr_word = 16'($urandom_range(255));
					default: thr_word = 16'($urandom_range(48));
				endcase
				thr_word[15:8] = 8'($urandom);
				case ($urandom_range(9))
					0: width_word = 16'd0;
					1: width_word = 16'd1;
					2: width_word = 16'd2;
					3: width_word = 16'd3;
					4: width_word = 16'($urandom_range(13, 48));
					default: width_word = 16'($urandom_range(1, 12));
				endcase
				width_word[15:12] = 4'($urandom);
				case ($urandom_range(7))
					0: height_word = 16'd0;
					1: height_word = 16'd1;
					2: height_word = 16'd2;
					default: height_word = 16'($urandom_range(3, 9));
				endcase
				configure(thr_word, width_word, height_word);
				scene_rgb = 24'($urandom);
				frames = $urandom_range(1, 3);
				for (int f = 0; f < frames; f++) begin
					if ($urandom_range(6) == 0) begin
						send_frame($urandom_range(0, eff_w * eff_h - 1), 1'b0);
						break;
					end
					send_frame(eff_w * eff_h, 1'b1);
				end
			end
			episode++;
		end

		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
